@@ hw/rtl/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
package psu_pkg;

  // Default line store sizing, in pixels of four bytes.
  localparam int unsigned PSU_MAX_WIDTH = 1024;

  // Fixed field widths of the channels and the configuration register.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned LW_W    = 11;

  // Row filter codes; anything above Paeth is held as the bad code.
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4,
    FLT_BAD   = 3'd5
  } filter_t;

endpackage

@@ hw/rtl/psu_if.sv @@
// ----------------------------------------------------------------------------
// psu_in_if / psu_out_if
// Valid/ready channels carrying stream bytes in and reconstructed pixels out.
// ----------------------------------------------------------------------------
interface psu_in_if import psu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface psu_out_if import psu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_argb;
  logic               row_end;
  logic               bad_filter;

  modport source (output valid, output pixel_argb, output row_end, output bad_filter,
                  input ready);
  modport sink   (input valid, input pixel_argb, input row_end, input bad_filter,
                  output ready);
endinterface

@@ hw/rtl/png_scanline_unfilter_rgba.sv @@
// ----------------------------------------------------------------------------
// png_scanline_unfilter_rgba
// Undoes the PNG row filters of an inflated 8-bit RGBA stream, emits ARGB pixels.
// ----------------------------------------------------------------------------
// Each byte is held in the stage A register, and each pixel in the output register.
// Throughput: one byte per cycle unless the output stalls, set by the single
// read and write port of the line store (read at acceptance, write in stage B).
// Filter bytes and the first three bytes of each pixel produce no result.
// Reset (rst_n low, synchronous) clears the row position, filter and width
// (to one pixel); the line store is not cleared and needs no clearing pass.
module png_scanline_unfilter_rgba import psu_pkg::*; #(
  parameter int unsigned MAX_WIDTH = PSU_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LW_W-1:0]  cfg_wdata,
  psu_in_if.sink           in_ch,
  psu_out_if.source        out_ch
);

  // Line store depth in bytes, its address width, and the width of a byte
  // position counter that can also hold the full row length.
  localparam int unsigned ROW_MAX = 4 * MAX_WIDTH;
  localparam int unsigned AW      = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int unsigned CW      = $clog2(ROW_MAX + 1);
  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  logic [LW_W-1:0] line_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_W'(1);
    end else if (cfg_we) begin
      line_width_r <= cfg_wdata;
    end
  end

  // The width is clamped to one pixel below and to the line store above.
  logic [WW-1:0] width_eff;
  logic [CW-1:0] row_bytes;

  always_comb begin
    if (line_width_r == '0) begin
      width_eff = WW'(1);
    end else if (32'(line_width_r) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(line_width_r);
    end
  end

  assign row_bytes = CW'({width_eff, 2'b00});

  // --------------------------------------------------------------------------
  // Stage A: acceptance. The row position is tracked here, and the line store
  // is read for the upper neighbour of each sample byte.
  // --------------------------------------------------------------------------
  logic [CW-1:0] byte_column_r;
  logic          first_row_r;
  filter_t       row_filter_r;

  logic              s1_valid_r;
  logic              s1_is_filter_r;
  logic [BYTE_W-1:0] s1_byte_r;
  filter_t           s1_flt_r;
  logic [AW-1:0]     s1_col_r;
  logic              s1_first_r;
  logic              s1_last_r;

  logic          in_fire;
  logic          b_fire;
  logic          b_emit;
  logic          is_filter;
  logic [CW-1:0] col_full;
  logic [AW-1:0] col;
  logic          row_last;
  filter_t       new_filter;

  assign in_ch.ready = !s1_valid_r || b_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // A byte is a filter byte at the start of each row, and always when it opens
  // a new image, whatever the row position had reached.
  assign is_filter  = in_ch.image_start || (byte_column_r == '0);
  assign col_full   = byte_column_r - CW'(1);
  assign col        = col_full[AW-1:0];
  // The column counter holds col+1, so the row ends once it reaches the length;
  // a width that shrank mid-row ends the row after this byte.
  assign row_last   = (byte_column_r >= row_bytes);
  assign new_filter = (in_ch.data_byte <= BYTE_W'(FLT_PAETH))
                      ? filter_t'(in_ch.data_byte[2:0]) : FLT_BAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_column_r <= '0;
      first_row_r   <= 1'b1;
      row_filter_r  <= FLT_NONE;
    end else if (in_fire) begin
      if (is_filter) begin
        row_filter_r  <= new_filter;
        byte_column_r <= CW'(1);
        if (in_ch.image_start) begin
          first_row_r <= 1'b1;
        end
      end else if (row_last) begin
        byte_column_r <= '0;
        first_row_r   <= 1'b0;
      end else begin
        byte_column_r <= byte_column_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (b_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Item payload carried into stage B; the filter travels with each byte so
  // that a new row's filter byte cannot overtake the last bytes of the old row.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_is_filter_r <= is_filter;
      s1_byte_r      <= in_ch.data_byte;
      s1_flt_r       <= row_filter_r;
      s1_col_r       <= col;
      s1_first_r     <= first_row_r;
      s1_last_r      <= row_last;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one byte per column of the previous reconstructed row. A column
  // is always rewritten at least a row before it is read again, so no bypass
  // is needed between the read in stage A and the write in stage B.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] line_mem [ROW_MAX];
  logic [BYTE_W-1:0] upper_rd_r;
  logic [BYTE_W-1:0] recon_byte;
  logic              mem_we;

  assign mem_we = b_fire && !s1_is_filter_r;

  always_ff @(posedge clk) begin
    if (in_fire && !is_filter) begin
      upper_rd_r <= line_mem[col];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[s1_col_r] <= recon_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: reconstruction. The read data is held while the stage stalls,
  // since stage A accepts nothing until stage B moves on.
  // --------------------------------------------------------------------------
  logic [PIXEL_W-1:0] left_bytes_r;
  logic [PIXEL_W-1:0] upper_left_bytes_r;
  logic [23:0]        pixel_partial_r;
  logic [BYTE_W-1:0]  upper_byte;

  logic               out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic               out_row_end_r;
  logic               out_bad_r;

  // In the first row of an image there is no upper neighbour.
  assign upper_byte = s1_first_r ? '0 : upper_rd_r;

  psu_recon u_recon (
    .x   (s1_byte_r),
    .a   (left_bytes_r[PIXEL_W-1 -: BYTE_W]),
    .b   (upper_byte),
    .c   (upper_left_bytes_r[PIXEL_W-1 -: BYTE_W]),
    .flt (s1_flt_r),
    .r   (recon_byte)
  );

  // Every fourth byte of a row completes a pixel. Only such a byte needs the
  // output register to be free; all others pass through stage B at once.
  assign b_emit = !s1_is_filter_r && (s1_col_r[1:0] == 2'b11);
  assign b_fire = s1_valid_r && (!b_emit || !out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bytes_r       <= '0;
      upper_left_bytes_r <= '0;
      pixel_partial_r    <= '0;
    end else if (b_fire) begin
      if (s1_is_filter_r) begin
        left_bytes_r       <= '0;
        upper_left_bytes_r <= '0;
        pixel_partial_r    <= '0;
      end else begin
        left_bytes_r       <= {left_bytes_r[23:0], recon_byte};
        upper_left_bytes_r <= {upper_left_bytes_r[23:0], upper_byte};
        pixel_partial_r    <= {pixel_partial_r[15:0], recon_byte};
      end
    end
  end

  // Output register: the pixel waits here until the sink takes the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && b_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Alpha is the fourth byte of the group, red, green and blue the first three.
  always_ff @(posedge clk) begin
    if (b_fire && b_emit) begin
      out_pixel_r   <= {recon_byte, pixel_partial_r};
      out_row_end_r <= s1_last_r;
      out_bad_r     <= (s1_flt_r == FLT_BAD);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_argb = out_pixel_r;
  assign out_ch.row_end    = out_row_end_r;
  assign out_ch.bad_filter = out_bad_r;

endmodule

@@ hw/rtl/psu_recon.sv @@
// ----------------------------------------------------------------------------
// psu_recon
// Reconstructs one filtered byte from its left, upper and upper-left bytes.
// ----------------------------------------------------------------------------
module psu_recon import psu_pkg::*; (
  input  logic [BYTE_W-1:0] x,
  input  logic [BYTE_W-1:0] a,
  input  logic [BYTE_W-1:0] b,
  input  logic [BYTE_W-1:0] c,
  input  filter_t           flt,
  output logic [BYTE_W-1:0] r
);

  // Paeth predictor: pa = |b-c|, pb = |a-c|, pc = |a+b-2c|, ties to a then b.
  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] pa_in,
                                              input logic [BYTE_W-1:0] pb_in,
                                              input logic [BYTE_W-1:0] pc_in);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic        [10:0] pa;
    logic        [10:0] pb;
    logic        [10:0] pc;
    da = $signed({3'b000, pb_in}) - $signed({3'b000, pc_in});
    db = $signed({3'b000, pa_in}) - $signed({3'b000, pc_in});
    dc = da + db;
    pa = (da < 0) ? 11'(-da) : 11'(da);
    pb = (db < 0) ? 11'(-db) : 11'(db);
    pc = (dc < 0) ? 11'(-dc) : 11'(dc);
    if (pa <= pb && pa <= pc) begin
      return pa_in;
    end else if (pb <= pc) begin
      return pb_in;
    end else begin
      return pc_in;
    end
  endfunction

  logic [BYTE_W:0] avg_sum;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    unique case (flt)
      FLT_NONE:  r = x;
      FLT_SUB:   r = x + a;
      FLT_UP:    r = x + b;
      FLT_AVG:   r = x + avg_sum[BYTE_W:1];
      FLT_PAETH: r = x + paeth(a, b, c);
      default:   r = x;
    endcase
  end

endmodule

@@ hw/rtl/psu_checker.sv @@
// ----------------------------------------------------------------------------
// psu_checker
// Port-level assertions on the PNG scanline unfilter block, bound to its top.
// ----------------------------------------------------------------------------
module psu_checker import psu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIXEL_W-1:0] out_pixel_argb,
  input logic               out_row_end,
  input logic               out_bad_filter
);

  // A stalled pixel stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled pixel withdrawn");

  // A stalled pixel keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_argb) && $stable(out_row_end)
                                && $stable(out_bad_filter))
    else $error("stalled pixel payload changed");

  // The input side only backs up when a finished pixel is held by the sink.
  a_ready_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A new pixel follows the transfer of its last byte through the stage A register and the output register.
  a_out_origin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("pixel appeared without a matching input transfer");

endmodule

bind png_scanline_unfilter_rgba psu_checker u_psu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pixel_argb (out_ch.pixel_argb),
  .out_row_end    (out_ch.row_end),
  .out_bad_filter (out_ch.bad_filter)
);
